// File: rtl/contiguous_port_range_allocator_assert.svh
// Assertion macros for the allocator's top-level RTL file.
`ifndef CONTIGUOUS_PORT_RANGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PORT_RANGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CPRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cpra_pkg.sv
// Types and constants shared by the contiguous port range allocator.
package cpra_pkg;

	// Port numbers and run lengths.
	localparam int PORT_W = 16;
	localparam int CNT_W = PORT_W + 1;

	// Widest scan word that the evaluation unit supports.
	localparam int MAX_WORD_BITS = 64;
	localparam int OFF_W = $clog2(MAX_WORD_BITS);

	// Request codes.
	localparam logic [1:0] REQ_RESERVE = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_MARK = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Status codes.
	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_BAD_RANGE = 2'd1;
	localparam logic [1:0] STS_NONE_FREE = 2'd2;

	// One request.
	typedef struct packed {
		logic [1:0]        req_type;
		logic [PORT_W-1:0] first_port;
		logic [PORT_W-1:0] last_port;
	} req_t;

	// One result.
	typedef struct packed {
		logic [1:0]        status;
		logic [PORT_W-1:0] granted_port;
	} resp_t;

	// Outcome of scanning one map word.
	typedef struct packed {
		logic             hit;
		logic [OFF_W-1:0] pos;
		logic [CNT_W-1:0] run;
	} eval_res_t;

endpackage

// File: rtl/cpra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module cpra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/cpra_word_eval.sv
// Run search over one map word: finds the lowest bit where a free run completes.
module cpra_word_eval #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0]       occ,
	input  logic [cpra_pkg::CNT_W-1:0] run_in,
	input  logic [cpra_pkg::CNT_W-1:0] need,
	output cpra_pkg::eval_res_t        res
);
	import cpra_pkg::*;

	logic [WORD_BITS-1:0] in_win;
	logic [WORD_BITS-1:0] reach;
	logic [WORD_BITS-1:0] nooc;
	logic [WORD_BITS-1:0] qual;
	logic [WORD_BITS-1:0] qlow;
	logic [WORD_BITS-1:0] rev;
	logic [WORD_BITS-1:0] rlow;
	logic [CNT_W-1:0]     diff;
	logic [OFF_W-1:0]     qpos;
	logic [OFF_W-1:0]     lead;

	// in_win[d]: a bit d places below the end still lies in the run.
	// reach[j]: the run carried in plus bits 0..j is long enough.
	always_comb begin
		diff = need - run_in - CNT_W'(1);
		for (int d = 0; d < WORD_BITS; d++) begin
			in_win[d] = need > CNT_W'(d);
			reach[d] = diff <= CNT_W'(d);
		end
	end

	// A run may end at bit j when no occupied bit falls in its window.
	for (genvar j = 0; j < WORD_BITS; j++) begin : g_win
		logic [WORD_BITS-1:0] win;
		always_comb begin
			win = '0;
			for (int k = 0; k <= j; k++) begin
				win[k] = occ[k] & in_win[j - k];
			end
		end
		assign nooc[j] = ~|win;
	end

	// Lowest qualifying end bit, and the free bits left at the top of the word.
	always_comb begin
		qual = nooc & reach;
		qlow = qual & (~qual + WORD_BITS'(1));
		for (int i = 0; i < WORD_BITS; i++) begin
			rev[i] = occ[WORD_BITS - 1 - i];
		end
		rlow = rev & (~rev + WORD_BITS'(1));
		qpos = '0;
		lead = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (qlow[i]) begin
				qpos = qpos | OFF_W'(i);
			end
			if (rlow[i]) begin
				lead = lead | OFF_W'(i);
			end
		end
		res.hit = |qual;
		res.pos = qpos;
		res.run = (~|occ) ? run_in + CNT_W'(WORD_BITS) : CNT_W'(lead);
	end

endmodule

// File: rtl/contiguous_port_range_allocator.sv
// Top level of the contiguous port range allocator: control, map memories, scan.
//
//  channel   ports              handshake
//  --------  -----------------  ----------------------------------------
//  request   req (req_t)        taken at a clock edge with start and !busy
//  result    resp (resp_t)      valid for one cycle while done is high
//
// Reserve: splits first_port into word and offset, then scans map words from the word of
// first_port up to the word where the run ends; it splits the run start again and walks the
// words that the run covers. With no fit the scan runs to the end of the space. Both stream
// one word a cycle. Release walks the words covered, mark sets one bound bit, and a bad range
// is answered from idle. Clear bound map sweeps the bound RAM, one word a cycle. After reset
// the same sweep clears both maps; busy stays high until it ends.
// The result side cannot stall; a result never holds off the next request.
`include "contiguous_port_range_allocator_assert.svh"

module contiguous_port_range_allocator #(
	parameter int NUM_PORTS = 65536,
	parameter int SCAN_WORD_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cpra_pkg::req_t  req,
	output logic            done,
	output cpra_pkg::resp_t resp
);
	import cpra_pkg::*;

	localparam int W = SCAN_WORD_BITS;
	localparam int WORDS = (NUM_PORTS + W - 1) / W;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int OW = (W > 1) ? $clog2(W) : 1;
	localparam int MW = $clog2(W + 1);
	localparam int LAST_BITS = NUM_PORTS - (WORDS - 1) * W;
	localparam int DIV_S = 22;
	localparam int DIV_MW = DIV_S + 1;
	localparam int PW_M = PORT_W + DIV_MW;
	localparam longint DIV_M = (longint'(1) << DIV_S) / W;
	localparam logic [W-1:0] ONES = '1;
	localparam logic [W-1:0] TOP_MASK = ONES << LAST_BITS;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	// Controller states.
	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_DIV2 = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_WALK = 3'd5;

	logic [2:0]        state_q;
	logic              clr_both_q;
	logic [AW-1:0]     clr_word_q;
	logic [1:0]        op_q;
	logic [CNT_W-1:0]  need_q;
	logic [PORT_W-1:0] div_port_q;
	logic              scanned_q;
	logic [AW-1:0]     est_q;
	logic [AW-1:0]     rd_word_q;
	logic [CNT_W-1:0]  base_q;
	logic [OW-1:0]     off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              more_q;
	logic              scan_first_q;
	logic [CNT_W-1:0]  run_q;
	logic [PORT_W-1:0] granted_q;
	logic              done_q;
	resp_t             resp_q;

	logic              v_s1;
	logic [AW-1:0]     word_s1;
	logic [CNT_W-1:0]  base_s1;
	logic              first_s1;
	logic [W-1:0]      mask_s1;

	logic              accept;
	logic              first_ok;
	logic              range_ok;
	logic [CNT_W-1:0]  req_need;
	logic [PW_M-1:0]   div_prod;
	logic [AW-1:0]     est_next;
	logic [CNT_W-1:0]  est_prod;
	logic [CNT_W-1:0]  rem_raw;
	logic              rem_hi;
	logic [AW-1:0]     word_fix;
	logic [OW-1:0]     off_fix;
	logic [CNT_W-1:0]  base_fix;
	logic [MW-1:0]     avail;
	logic [MW-1:0]     take;
	logic [W-1:0]      walk_mask;
	logic [W-1:0]      occ;
	eval_res_t         ev;
	logic [CNT_W-1:0]  run_start;

	logic              alloc_we;
	logic              bound_we;
	logic [AW-1:0]     wr_addr;
	logic [W-1:0]      alloc_wd;
	logic [W-1:0]      bound_wd;
	logic [W-1:0]      alloc_rd;
	logic [W-1:0]      bound_rd;

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign resp = resp_q;

	// Request checks at acceptance.
	always_comb begin
		accept = start && !busy;
		first_ok = {1'b0, req.first_port} < CNT_W'(NUM_PORTS);
		range_ok = (req.first_port <= req.last_port)
			&& ({1'b0, req.last_port} < CNT_W'(NUM_PORTS));
		req_need = {1'b0, req.last_port} - {1'b0, req.first_port} + CNT_W'(1);
	end

	// Word index and bit offset of a port: reciprocal multiply, then one correction.
	always_comb begin
		div_prod = PW_M'(div_port_q) * PW_M'(DIV_M);
		est_next = AW'(div_prod >> DIV_S);
		est_prod = CNT_W'(est_q) * CNT_W'(W);
		rem_raw = {1'b0, div_port_q} - est_prod;
		rem_hi = rem_raw >= CNT_W'(W);
		word_fix = rem_hi ? est_q + AW'(1) : est_q;
		off_fix = rem_hi ? OW'(rem_raw - CNT_W'(W)) : OW'(rem_raw);
		base_fix = rem_hi ? est_prod + CNT_W'(W) : est_prod;
	end

	// Bits of the current word that a range walk touches.
	always_comb begin
		avail = MW'(W) - MW'(off_q);
		take = (cnt_q < CNT_W'(avail)) ? MW'(cnt_q) : avail;
		walk_mask = (~(ONES << take)) << off_q;
	end

	// Occupied bits of a scanned word: taken, bound, below the first port or past the space.
	always_comb begin
		occ = alloc_rd | bound_rd;
		if (first_s1) begin
			occ = occ | ~(ONES << off_q);
		end
		if (word_s1 == LAST_WORD) begin
			occ = occ | TOP_MASK;
		end
	end

	cpra_word_eval #(
		.WORD_BITS (W)
	) u_eval (
		.occ    (occ),
		.run_in (run_q),
		.need   (need_q),
		.res    (ev)
	);

	assign run_start = base_s1 + CNT_W'(ev.pos) + CNT_W'(1) - need_q;

	// Map write port: clearing sweep, or read-modify-write of the word read last cycle.
	always_comb begin
		alloc_we = 1'b0;
		bound_we = 1'b0;
		wr_addr = word_s1;
		alloc_wd = alloc_rd | mask_s1;
		bound_wd = bound_rd | mask_s1;
		priority if (state_q == S_CLR) begin
			wr_addr = clr_word_q;
			alloc_we = clr_both_q;
			bound_we = 1'b1;
			alloc_wd = '0;
			bound_wd = '0;
		end else if (state_q == S_WALK && v_s1) begin
			if (op_q == REQ_MARK) begin
				bound_we = 1'b1;
			end else begin
				alloc_we = 1'b1;
				if (op_q == REQ_RELEASE) begin
					alloc_wd = alloc_rd & ~mask_s1;
				end
			end
		end else begin
			alloc_we = 1'b0;
		end
	end

	cpra_ram #(
		.WIDTH (W),
		.DEPTH (WORDS)
	) u_alloc_ram (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (wr_addr),
		.wdata (alloc_wd),
		.raddr (rd_word_q),
		.rdata (alloc_rd)
	);

	cpra_ram #(
		.WIDTH (W),
		.DEPTH (WORDS)
	) u_bound_ram (
		.clk   (clk),
		.we    (bound_we),
		.waddr (wr_addr),
		.wdata (bound_wd),
		.raddr (rd_word_q),
		.rdata (bound_rd)
	);

	// Control flow and the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_both_q <= 1'b1;
			clr_word_q <= '0;
			done_q <= 1'b0;
			v_s1 <= 1'b0;
			more_q <= 1'b0;
			scan_first_q <= 1'b0;
			scanned_q <= 1'b0;
			cnt_q <= '0;
			rd_word_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_word_q <= clr_word_q + AW'(1);
					if (clr_word_q == LAST_WORD) begin
						state_q <= S_IDLE;
						clr_both_q <= 1'b0;
						if (!clr_both_q) begin
							done_q <= 1'b1;
							resp_q <= '{status: STS_OK, granted_port: '0};
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= req.req_type;
						need_q <= req_need;
						div_port_q <= req.first_port;
						scanned_q <= 1'b0;
						unique case (req.req_type)
							REQ_RESERVE, REQ_RELEASE: begin
								if (range_ok) begin
									cnt_q <= req_need;
									state_q <= S_DIV1;
								end else begin
									done_q <= 1'b1;
									resp_q <= '{status: STS_BAD_RANGE, granted_port: '0};
								end
							end
							REQ_MARK: begin
								if (first_ok) begin
									cnt_q <= CNT_W'(1);
									state_q <= S_DIV1;
								end else begin
									done_q <= 1'b1;
									resp_q <= '{status: STS_BAD_RANGE, granted_port: '0};
								end
							end
							REQ_CLEAR: begin
								clr_word_q <= '0;
								state_q <= S_CLR;
							end
						endcase
					end
				end
				S_DIV1: begin
					est_q <= est_next;
					v_s1 <= 1'b0;
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					rd_word_q <= word_fix;
					off_q <= off_fix;
					base_q <= base_fix;
					more_q <= 1'b1;
					scan_first_q <= 1'b1;
					run_q <= '0;
					state_q <= (op_q == REQ_RESERVE && !scanned_q) ? S_SCAN : S_WALK;
				end
				S_SCAN: begin
					// Issue one word a cycle until the last word of the space.
					if (more_q) begin
						v_s1 <= 1'b1;
						word_s1 <= rd_word_q;
						base_s1 <= base_q;
						first_s1 <= scan_first_q;
						scan_first_q <= 1'b0;
						rd_word_q <= rd_word_q + AW'(1);
						base_q <= base_q + CNT_W'(W);
						more_q <= rd_word_q != LAST_WORD;
					end else begin
						v_s1 <= 1'b0;
					end
					// Evaluate the word read last cycle.
					if (v_s1) begin
						if (ev.hit) begin
							granted_q <= run_start[PORT_W-1:0];
							div_port_q <= run_start[PORT_W-1:0];
							cnt_q <= need_q;
							scanned_q <= 1'b1;
							state_q <= S_DIV1;
						end else begin
							run_q <= ev.run;
							if (word_s1 == LAST_WORD) begin
								done_q <= 1'b1;
								resp_q <= '{status: STS_NONE_FREE, granted_port: '0};
								v_s1 <= 1'b0;
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_WALK: begin
					// Read one word ahead; the write of the previous word happens alongside.
					if (cnt_q != '0) begin
						v_s1 <= 1'b1;
						word_s1 <= rd_word_q;
						first_s1 <= 1'b0;
						mask_s1 <= walk_mask;
						rd_word_q <= rd_word_q + AW'(1);
						off_q <= '0;
						cnt_q <= cnt_q - CNT_W'(take);
					end else begin
						v_s1 <= 1'b0;
						done_q <= 1'b1;
						resp_q.status <= STS_OK;
						resp_q.granted_port <= (op_q == REQ_RESERVE) ? granted_q : '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Only the reset sweep writes both maps in one cycle.
	`CPRA_ASSERT_NOW(a_dual_write, alloc_we && bound_we, state_q == S_CLR && clr_both_q, "both maps written outside the reset sweep")
	// A valid reserve always starts a scan.
	`CPRA_ASSERT_NEXT(a_reserve_busy, accept && req.req_type == REQ_RESERVE && range_ok, busy, "valid reserve did not start")
	// Only a successful reserve reports a port.
	`CPRA_ASSERT_NOW(a_grant_zero, done && resp.status != STS_OK, resp.granted_port == '0, "port reported on a failed request")
	// Every word of a range walk has at least one bit in its write mask.
	`CPRA_ASSERT_NOW(a_walk_mask, state_q == S_WALK && v_s1, mask_s1 != '0, "empty write mask in range walk")

endmodule
